@@ hdl/lcdws_pkg.sv @@
// shared types and constants of the character lcd write sequencer
`timescale 1ns / 1ps

package lcdws_pkg;

    // field widths of the item channels
    localparam int FUNC_W = 2;
    localparam int BYTE_W = 8;
    localparam int ROW_W  = 3;
    localparam int COL_W  = 6;
    localparam int HOLD_W = 16;

    // apb port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // function codes of an input item
    localparam logic [FUNC_W-1:0] FUNC_CMD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // row codes for a cursor move
    localparam logic [ROW_W-1:0] ROW_0 = 3'd0;
    localparam logic [ROW_W-1:0] ROW_1 = 3'd1;
    localparam logic [ROW_W-1:0] ROW_2 = 3'd2;
    localparam logic [ROW_W-1:0] ROW_3 = 3'd3;

    // ddram address offsets and the set-address command
    localparam logic [BYTE_W-1:0] ROW1_OFS  = 8'h40;
    localparam logic [BYTE_W-1:0] ROW2_OFS  = 8'h14;
    localparam logic [BYTE_W-1:0] ROW3_OFS  = 8'h54;
    localparam logic [BYTE_W-1:0] SET_DDRAM = 8'h80;

    // port latch halves
    localparam logic [BYTE_W-1:0] NIB_LO_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] NIB_HI_MASK = 8'hF0;

    // register indexes (word address bits)
    localparam logic [1:0] REG_FOUR_BIT  = 2'd0;
    localparam logic [1:0] REG_NIB_UPPER = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;

    // register reset values
    localparam logic              FOUR_BIT_RST  = 1'b0;
    localparam logic              NIB_UPPER_RST = 1'b1;
    localparam logic [HOLD_W-1:0] HOLD_RST      = 16'd1000;

    // classified write queued between front and back
    typedef struct packed {
        logic              rs;
        logic [BYTE_W-1:0] val;
    } t_cmd;

    // configuration seen by the back end
    typedef struct packed {
        logic              four_bit;
        logic              nib_upper;
        logic [HOLD_W-1:0] hold;
    } t_cfg;

endpackage

@@ hdl/lcdws_if.sv @@
// item channel interfaces of the character lcd write sequencer
`timescale 1ns / 1ps

interface lcdws_in_if import lcdws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] byte_value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;

    modport source (output valid, func, byte_value, row, col, input ready);
    modport sink   (input valid, func, byte_value, row, col, output ready);
endinterface

interface lcdws_out_if import lcdws_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              reg_select;
    logic              read_write;
    logic              enable;
    logic [BYTE_W-1:0] data_bus;
    logic              last;

    modport source (output valid, reg_select, read_write, enable, data_bus, last,
                    input ready);
    modport sink   (input valid, reg_select, read_write, enable, data_bus, last,
                    output ready);
endinterface

@@ hdl/lcd_parallel_write_sequencer.sv @@
// Character LCD parallel write sequencer. Each input item (command byte, display character
// or cursor move) becomes a series of pin-phase items on the output: four phases on an
// 8-bit bus, seven on a 4-bit bus, the last one flagged. Each phase is held for the
// configured hold (a hold of zero acts as one) by the hold counter in the back-end
// sequencer, and a phase also waits while the output is not ready. Items with the unused
// function code are accepted and produce nothing. A small queue between the classifying
// front end and the sequencer lets input accept while phases are still being played out.
// Configuration is to be written through the APB port only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps

module lcd_parallel_write_sequencer import lcdws_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcdws_in_if.sink              i_in,
    lcdws_out_if.source           o_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    t_cfg cfg;
    logic push;
    t_cmd push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    t_cmd head_cmd;

    // configuration registers
    lcdws_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // accept and classify
    lcdws_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    // decoupling queue
    lcdws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_cmd      (head_cmd)
    );

    // phase sequencer
    lcdws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

@@ hdl/lcdws_cfg.sv @@
// apb configuration registers of the character lcd write sequencer
`timescale 1ns / 1ps

module lcdws_cfg import lcdws_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output logic [APB_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output t_cfg                  o_cfg
);

    logic              r_four_bit;
    logic              r_nib_upper;
    logic [HOLD_W-1:0] r_hold;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign wr_en    = i_psel & i_penable & i_pwrite;
    assign reg_idx  = i_paddr[3:2];
    assign o_pready = 1'b1;

    // register writes in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit  <= FOUR_BIT_RST;
            r_nib_upper <= NIB_UPPER_RST;
            r_hold      <= HOLD_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_FOUR_BIT:  r_four_bit  <= i_pwdata[0];
                REG_NIB_UPPER: r_nib_upper <= i_pwdata[0];
                REG_HOLD:      r_hold      <= i_pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_FOUR_BIT:  o_prdata = {{(APB_DATA_W-1){1'b0}}, r_four_bit};
            REG_NIB_UPPER: o_prdata = {{(APB_DATA_W-1){1'b0}}, r_nib_upper};
            REG_HOLD:      o_prdata = {{(APB_DATA_W-HOLD_W){1'b0}}, r_hold};
            default:       o_prdata = '0;
        endcase
    end

    assign o_cfg = '{four_bit: r_four_bit, nib_upper: r_nib_upper, hold: r_hold};

endmodule

@@ hdl/lcdws_front.sv @@
// front end: accepts input items and turns them into register writes
`timescale 1ns / 1ps

module lcdws_front import lcdws_pkg::*; (
    lcdws_in_if.sink i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [BYTE_W-1:0] col_ext;
    logic [BYTE_W-1:0] addr;

    assign col_ext = {{(BYTE_W-COL_W){1'b0}}, i_in.col};

    // ddram address for a cursor move, unknown rows go home
    always_comb begin
        unique case (i_in.row)
            ROW_0:   addr = col_ext;
            ROW_1:   addr = col_ext + ROW1_OFS;
            ROW_2:   addr = col_ext + ROW2_OFS;
            ROW_3:   addr = col_ext + ROW3_OFS;
            default: addr = '0;
        endcase
    end

    // classify: cursor moves become commands, unused code is dropped
    always_comb begin
        if (i_in.func == FUNC_MOVE) begin
            o_cmd.rs  = 1'b0;
            o_cmd.val = SET_DDRAM | addr;
        end else begin
            o_cmd.rs  = i_in.func[0];
            o_cmd.val = i_in.byte_value;
        end
    end

    assign i_in.ready = ~i_full;
    assign o_push     = i_in.valid & ~i_full & (i_in.func != FUNC_NONE);

endmodule

@@ hdl/lcdws_queue.sv @@
// small fifo of classified writes between front and back
`timescale 1ns / 1ps

module lcdws_queue import lcdws_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

@@ hdl/lcdws_back.sv @@
// back end: steps each write through its pin phases with a hold counter
`timescale 1ns / 1ps

module lcdws_back import lcdws_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_pop,
    lcdws_out_if.source   o_out
);

    typedef enum logic [2:0] {
        PH_RS    = 3'd0,
        PH_E1_HI = 3'd1,
        PH_D1    = 3'd2,
        PH_E1_LO = 3'd3,
        PH_E2_HI = 3'd4,
        PH_D2    = 3'd5,
        PH_E2_LO = 3'd6
    } t_phase;

    t_phase            r_phase;
    logic              r_busy;
    t_cmd              r_cmd;
    logic [HOLD_W-1:0] r_hold;
    logic [BYTE_W-1:0] r_latch;
    logic              r_en;
    logic              r_out_valid;
    logic              r_out_rs;
    logic              r_out_en;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    logic              emit;
    logic              is_last;
    logic              n_en;
    logic [BYTE_W-1:0] n_latch;
    logic [HOLD_W-1:0] hold_load;

    function automatic logic [BYTE_W-1:0] place_nib(input logic [BYTE_W-1:0] latch,
                                                    input logic [3:0] nib,
                                                    input logic upper);
        return upper ? ({nib, 4'h0} | (latch & NIB_LO_MASK))
                     : ({4'h0, nib} | (latch & NIB_HI_MASK));
    endfunction

    // next phase once the hold has run out and the output slot is free
    assign emit      = r_busy && (r_hold == '0) && (!r_out_valid || o_out.ready);
    assign o_pop     = i_cmd_valid && (!r_busy || (emit && is_last));
    assign hold_load = (i_cfg.hold == '0) ? '0 : i_cfg.hold - 1'b1;

    // pin levels for the current phase
    always_comb begin
        n_en    = r_en;
        n_latch = r_latch;
        is_last = 1'b0;
        unique case (r_phase)
            PH_RS: ;
            PH_E1_HI: n_en = 1'b1;
            PH_D1: begin
                if (i_cfg.four_bit) begin
                    n_latch = place_nib(r_latch, r_cmd.val[7:4], i_cfg.nib_upper);
                end else begin
                    n_latch = r_cmd.val;
                end
            end
            PH_E1_LO: begin
                n_en    = 1'b0;
                is_last = ~i_cfg.four_bit;
            end
            PH_E2_HI: n_en = 1'b1;
            PH_D2:    n_latch = place_nib(r_latch, r_cmd.val[3:0], i_cfg.nib_upper);
            PH_E2_LO: begin
                n_en    = 1'b0;
                is_last = 1'b1;
            end
            default: ;
        endcase
    end

    // sequencer state, pin state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RS;
            r_busy      <= 1'b0;
            r_hold      <= '0;
            r_latch     <= '0;
            r_en        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cmd  <= i_cmd;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_en        <= n_en;
                r_latch     <= n_latch;
                r_out_valid <= 1'b1;
                r_out_rs    <= r_cmd.rs;
                r_out_en    <= n_en;
                r_out_data  <= n_latch;
                r_out_last  <= is_last;
                r_hold      <= hold_load;
                r_phase     <= is_last ? PH_RS : t_phase'(r_phase + 3'd1);
            end else begin
                if (o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (r_hold != '0) begin
                    r_hold <= r_hold - 1'b1;
                end
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.reg_select = r_out_rs;
    assign o_out.read_write = 1'b0;
    assign o_out.enable     = r_out_en;
    assign o_out.data_bus   = r_out_data;
    assign o_out.last       = r_out_last;

    // no phase leaves before its hold has run out
    a_hold_respected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold != '0 |-> !emit)
        else $error("phase emitted during hold");

    // a transfer ends only on the closing enable-low phase of its mode
    a_last_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && is_last |-> (r_phase == PH_E1_LO && !i_cfg.four_bit) || r_phase == PH_E2_LO)
        else $error("transfer ended on wrong phase");

    // the final phase of each item leaves the strobe low
    a_last_strobe_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> !r_out_en)
        else $error("enable high on final phase");

    // an idle sequencer waits at the first phase
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_phase == PH_RS)
        else $error("idle sequencer off first phase");

endmodule
